FILE: rtl/elip_pkg.sv
// elip_pkg: shared types and character codes for the edge list parser
// no dependencies; imported by elip_step and edge_list_integer_parser_top
package elip_pkg;

    // default magnitude width of the parsed numbers
    localparam int VALUE_BITS_DEF = 32;

    localparam int HDR_BITS   = 16;
    localparam int BYTE_BITS  = 8;
    localparam int LEFT_BITS  = 32;
    localparam int RIGHT_BITS = 31;
    localparam int DATA_BITS  = 64;
    localparam int USER_BITS  = 2;

    localparam logic [BYTE_BITS-1:0] CH_NL    = 8'h0a;
    localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CH_VT    = 8'h0b;
    localparam logic [BYTE_BITS-1:0] CH_FF    = 8'h0c;
    localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_BITS-1:0] CH_STAR  = 8'h2a;
    localparam logic [BYTE_BITS-1:0] CH_PLUS  = 8'h2b;
    localparam logic [BYTE_BITS-1:0] CH_MINUS = 8'h2d;
    localparam logic [BYTE_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_NINE  = 8'h39;

    // parser phase, one-hot
    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_START   = 8'b0000_0010,
        PH_COMMENT = 8'b0000_0100,
        PH_LWS     = 8'b0000_1000,
        PH_LNUM    = 8'b0001_0000,
        PH_GAP     = 8'b0010_0000,
        PH_RNUM    = 8'b0100_0000,
        PH_TAIL    = 8'b1000_0000
    } phase_t;

    // control part of the per-line state
    typedef struct packed {
        phase_t                phase;
        logic [HDR_BITS-1:0]   header_count;
        logic                  left_negative;
        logic                  left_digits_seen;
        logic                  overflow_seen;
    } ctl_t;

    // one finished edge
    typedef struct packed {
        logic [LEFT_BITS-1:0]  left_vertex;
        logic [RIGHT_BITS-1:0] right_vertex;
        logic                  left_empty;
        logic                  saturated;
    } edge_t;

endpackage

FILE: rtl/elip_step.sv
// elip_step: next-state and result logic for one input byte
// depends on elip_pkg; pure combinational, registers live in the top level
module elip_step
    import elip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic [HDR_BITS-1:0]   header_lines,
    input  logic [BYTE_BITS-1:0]  byte_in,
    input  ctl_t                  ctl,
    input  logic [VALUE_BITS-1:0] left_acc,
    input  logic [VALUE_BITS-2:0] right_acc,
    output ctl_t                  ctl_next,
    output logic [VALUE_BITS-1:0] left_acc_next,
    output logic [VALUE_BITS-2:0] right_acc_next,
    output logic                  emit,
    output edge_t                 result
);

    localparam int AW = VALUE_BITS + 4;
    localparam logic [AW-1:0] POS_LIMIT = (AW'(1) << (VALUE_BITS - 1)) - AW'(1);

    logic                  is_nl;
    logic                  is_digit;
    logic                  is_space;
    logic                  is_cmt;
    logic                  hdr_hold;
    phase_t                ph0;
    phase_t                ph1;
    logic [AW-1:0]         digit;
    logic [AW-1:0]         l_prod;
    logic [AW-1:0]         l_cap;
    logic                  l_over;
    logic [VALUE_BITS-1:0] l_new;
    logic [AW-1:0]         r_prod;
    logic                  r_over;
    logic [VALUE_BITS-2:0] r_new;
    logic [VALUE_BITS-1:0] l_signed;

    assign is_nl    = (byte_in == CH_NL);
    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign is_space = byte_in inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
    assign is_cmt   = (byte_in == CH_HASH) || (byte_in == CH_STAR);

    assign hdr_hold = (ctl.phase == PH_HEADER) && (ctl.header_count < header_lines);
    assign ph0      = (ctl.phase == PH_HEADER) ? PH_START : ctl.phase;
    assign ph1      = (ph0 == PH_START) ? PH_LWS : ph0;

    // acc*10 + d against the cap; exceeding the cap saturates
    assign digit  = AW'(byte_in[3:0]);
    assign l_prod = (AW'(left_acc) << 3) + (AW'(left_acc) << 1) + digit;
    assign l_cap  = POS_LIMIT + AW'(ctl.left_negative);
    assign l_over = (l_prod > l_cap);
    assign l_new  = l_over ? l_cap[VALUE_BITS-1:0] : l_prod[VALUE_BITS-1:0];

    assign r_prod = (AW'(right_acc) << 3) + (AW'(right_acc) << 1) + digit;
    assign r_over = (r_prod > POS_LIMIT);
    assign r_new  = r_over ? POS_LIMIT[VALUE_BITS-2:0] : r_prod[VALUE_BITS-2:0];

    // result from the state held before the newline
    assign l_signed = ctl.left_negative ? ({VALUE_BITS{1'b0}} - left_acc) : left_acc;
    assign result.left_vertex  = LEFT_BITS'(signed'(l_signed));
    assign result.right_vertex = RIGHT_BITS'(right_acc);
    assign result.left_empty   = !ctl.left_digits_seen;
    assign result.saturated    = ctl.overflow_seen;

    always_comb
    begin
        ctl_next       = ctl;
        left_acc_next  = left_acc;
        right_acc_next = right_acc;
        emit           = 1'b0;

        if (hdr_hold)
        begin
            if (is_nl)
            begin
                ctl_next.header_count = ctl.header_count + HDR_BITS'(1);
            end
        end
        else if (ph0 == PH_COMMENT)
        begin
            ctl_next.phase = is_nl ? PH_START : PH_COMMENT;
        end
        else if ((ph0 == PH_START) && is_cmt)
        begin
            ctl_next.phase = PH_COMMENT;
        end
        else if (is_nl)
        begin
            emit                      = 1'b1;
            ctl_next.phase            = PH_START;
            ctl_next.left_negative    = 1'b0;
            ctl_next.left_digits_seen = 1'b0;
            ctl_next.overflow_seen    = 1'b0;
            left_acc_next             = '0;
            right_acc_next            = '0;
        end
        else
        begin
            ctl_next.phase = ph1;
            unique case (ph1)
                PH_LWS:
                begin
                    if (is_space)
                    begin
                        ctl_next.phase = PH_LWS;
                    end
                    else if (byte_in == CH_PLUS)
                    begin
                        ctl_next.left_negative = 1'b0;
                        ctl_next.phase         = PH_LNUM;
                    end
                    else if (byte_in == CH_MINUS)
                    begin
                        ctl_next.left_negative = 1'b1;
                        ctl_next.phase         = PH_LNUM;
                    end
                    else if (is_digit)
                    begin
                        left_acc_next             = l_new;
                        ctl_next.left_digits_seen = 1'b1;
                        ctl_next.overflow_seen    = ctl.overflow_seen | l_over;
                        ctl_next.phase            = PH_LNUM;
                    end
                    else
                    begin
                        ctl_next.phase = PH_GAP;
                    end
                end
                PH_LNUM:
                begin
                    if (is_digit)
                    begin
                        left_acc_next             = l_new;
                        ctl_next.left_digits_seen = 1'b1;
                        ctl_next.overflow_seen    = ctl.overflow_seen | l_over;
                    end
                    else
                    begin
                        ctl_next.phase = PH_GAP;
                    end
                end
                PH_GAP:
                begin
                    if (is_digit)
                    begin
                        right_acc_next         = r_new;
                        ctl_next.overflow_seen = ctl.overflow_seen | r_over;
                        ctl_next.phase         = PH_RNUM;
                    end
                end
                PH_RNUM:
                begin
                    if (is_digit)
                    begin
                        right_acc_next         = r_new;
                        ctl_next.overflow_seen = ctl.overflow_seen | r_over;
                    end
                    else
                    begin
                        ctl_next.phase = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    ctl_next.phase = PH_TAIL;
                end
                default:
                begin
                    ctl_next.phase = ph1;
                end
            endcase
        end
    end

endmodule

FILE: rtl/edge_list_integer_parser_top.sv
// edge_list_integer_parser_top: streaming edge list text parser, top level
// depends on elip_pkg and elip_step
//
// takes ascii text one byte per word on s_axis and returns one edge word on
// m_axis for every edge line, at that line's newline. the first header_lines
// lines are dropped (the register is only looked at before the first edge
// line, so write it right after reset); lines that start with '#' or '*' are
// comments. the first number is read like strtol (white space, sign, digits),
// the second as a plain digit run, the rest of the line is ignored. numbers
// saturate to the VALUE_BITS signed range and set the saturated flag; a
// first number with no digits reads as 0 with left_empty set. throughput is
// one byte per clock while s_axis_tready is high: the whole per-byte update
// is one pass through the step logic into the state registers. an edge
// appears on m_axis in the cycle after its newline is taken. s_axis_tready
// only drops while a finished edge sits in the output register and the sink
// is not taking it. no memories, so no clearing pass after reset.
module edge_list_integer_parser_top
    import elip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration: header_lines
    input  logic                  cfg_we,
    input  logic [HDR_BITS-1:0]   cfg_wdata,

    // input text
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_BITS-1:0]  s_axis_tdata,   // [7:0] byte_in

    // parsed edges
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_BITS-1:0]  m_axis_tdata,   // [31:0] left_vertex, [62:32] right_vertex,
                                                  // [63] zero
    output logic [USER_BITS-1:0]  m_axis_tuser    // [0] left_empty, [1] saturated
);

    localparam logic [VALUE_BITS-1:0] LEFT_MAX = VALUE_BITS'(1) << (VALUE_BITS - 1);

    logic [HDR_BITS-1:0]   header_lines_reg;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [VALUE_BITS-1:0] left_acc_reg;
    logic [VALUE_BITS-1:0] left_acc_next;
    logic [VALUE_BITS-2:0] right_acc_reg;
    logic [VALUE_BITS-2:0] right_acc_next;
    logic                  emit;
    edge_t                 result;
    edge_t                 out_reg;
    logic                  out_valid_reg;
    logic                  in_acc;

    // output register free or draining this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    elip_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .header_lines   (header_lines_reg),
        .byte_in        (s_axis_tdata),
        .ctl            (ctl_reg),
        .left_acc       (left_acc_reg),
        .right_acc      (right_acc_reg),
        .ctl_next       (ctl_next),
        .left_acc_next  (left_acc_next),
        .right_acc_next (right_acc_next),
        .emit           (emit),
        .result         (result)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_lines_reg <= '0;
        end
        else if (cfg_we)
        begin
            header_lines_reg <= cfg_wdata;
        end
    end

    // parser state, advanced once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase            <= PH_HEADER;
            ctl_reg.header_count     <= '0;
            ctl_reg.left_negative    <= 1'b0;
            ctl_reg.left_digits_seen <= 1'b0;
            ctl_reg.overflow_seen    <= 1'b0;
            left_acc_reg             <= '0;
            right_acc_reg            <= '0;
        end
        else if (in_acc)
        begin
            ctl_reg       <= ctl_next;
            left_acc_reg  <= left_acc_next;
            right_acc_reg <= right_acc_next;
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc && emit)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.right_vertex, out_reg.left_vertex};
    assign m_axis_tuser  = {out_reg.saturated, out_reg.left_empty};

`ifndef SYNTH
    // a newline on an edge line must show up on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && emit) |=> m_axis_tvalid)
        else $error("edge word lost after newline");

    // line state is cleared after every emitted edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && emit) |=> (left_acc_reg == '0 && right_acc_reg == '0
                              && !ctl_reg.overflow_seen && !ctl_reg.left_digits_seen
                              && ctl_reg.phase == PH_START))
        else $error("line state not cleared after edge");

    // comment lines never produce an edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && ctl_reg.phase == PH_COMMENT) |-> !emit)
        else $error("edge emitted inside a comment line");

    // first magnitude never passes the negative limit
    assert property (@(posedge clk) disable iff (!rst_n)
        left_acc_reg <= LEFT_MAX)
        else $error("left accumulator beyond saturation limit");
`endif

endmodule

FILE: sim/tb_edge_list_integer_parser_top.sv
// tb_edge_list_integer_parser_top: self-checking testbench for the edge list parser
// streams text bytes in, predicts every edge word and checks it on m_axis
// depends on elip_pkg and edge_list_integer_parser_top
`timescale 1ns / 1ps

module tb_edge_list_integer_parser_top;

    import elip_pkg::*;

    // no word moving on either side for this many cycles means a hang
    localparam int QUIET_LIMIT  = 4000;
    // edge word shows up in the cycle after its newline; settle idles this long at the end
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 720;

    // largest positive magnitude of a parsed number
    localparam logic [63:0] MAG_MAX = (64'd1 << (VALUE_BITS_DEF - 1)) - 64'd1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [HDR_BITS-1:0]  cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_BITS-1:0] s_axis_tdata = '0;   // [7:0] byte_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_BITS-1:0] m_axis_tdata;        // [31:0] left_vertex, [62:32] right_vertex,
                                               // [63] zero
    logic [USER_BITS-1:0] m_axis_tuser;        // [0] left_empty, [1] saturated

    // idle rates in percent, changed per test phase
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    int fail_count  = 0;
    int quiet_cycles = 0;
    int random_sent = 0;

    // edges the parser still owes us, oldest first
    edge_t edges_due[$];

    // bytes of the line being built by the random generator
    logic [BYTE_BITS-1:0] text_line[$];

    // parser shadow: register, header progress and the line being parsed
    logic [HDR_BITS-1:0] hdr_limit    = '0;
    logic [HDR_BITS-1:0] hdr_count    = '0;
    phase_t              ln_phase     = PH_HEADER;
    logic [63:0]         ln_left      = '0;
    logic                ln_neg       = 1'b0;
    logic [63:0]         ln_right     = '0;
    logic                ln_left_seen = 1'b0;
    logic                ln_sat       = 1'b0;

    edge_list_integer_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // edge prediction
    // ------------------------------------------------------------------

    // space, tab, vertical tab, form feed, carriage return; never newline
    function automatic bit is_blank(input logic [BYTE_BITS-1:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR;
    endfunction

    function automatic bit is_num(input logic [BYTE_BITS-1:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // shift one decimal digit into a magnitude; clamps at cap and flags the line
    function automatic logic [63:0] add_digit(input logic [63:0] acc,
                                              input logic [BYTE_BITS-1:0] b,
                                              input logic [63:0] cap);
        logic [63:0] d;
        d = 64'(b) - 64'(CH_ZERO);
        if (acc > (cap - d) / 64'd10)
        begin
            ln_sat = 1'b1;
            return cap;
        end
        return acc * 64'd10 + d;
    endfunction

    task automatic clear_line();
        ln_left      = '0;
        ln_neg       = 1'b0;
        ln_right     = '0;
        ln_left_seen = 1'b0;
        ln_sat       = 1'b0;
    endtask

    // advance the shadow parser by one accepted byte; queue an edge at a newline
    task automatic parse_byte(input logic [BYTE_BITS-1:0] b);
        logic [63:0] lcap;
        logic [63:0] lval;
        edge_t       e;

        // header lines are only counted, never parsed
        if (ln_phase == PH_HEADER)
        begin
            if (hdr_count < hdr_limit)
            begin
                if (b == CH_NL)
                    hdr_count = hdr_count + HDR_BITS'(1);
                return;
            end
            ln_phase = PH_START;
        end

        if (ln_phase == PH_COMMENT)
        begin
            if (b == CH_NL)
                ln_phase = PH_START;
            return;
        end

        // comment marker only counts as the very first byte of a line
        if (ln_phase == PH_START)
        begin
            if (b == CH_HASH || b == CH_STAR)
            begin
                ln_phase = PH_COMMENT;
                return;
            end
            ln_phase = PH_LWS;
        end

        // newline closes every edge line, whatever phase it is in
        if (b == CH_NL)
        begin
            lval           = ln_neg ? (64'd0 - ln_left) : ln_left;
            e.left_vertex  = lval[LEFT_BITS-1:0];
            e.right_vertex = ln_right[RIGHT_BITS-1:0];
            e.left_empty   = !ln_left_seen;
            e.saturated    = ln_sat;
            edges_due.insert(edges_due.size(), e);
            clear_line();
            ln_phase = PH_START;
            return;
        end

        // a negative number may reach one further than a positive one
        lcap = MAG_MAX + (ln_neg ? 64'd1 : 64'd0);
        case (ln_phase)
            PH_LWS:
            begin
                if (!is_blank(b))
                begin
                    if (b == CH_PLUS)
                    begin
                        ln_neg   = 1'b0;
                        ln_phase = PH_LNUM;
                    end
                    else if (b == CH_MINUS)
                    begin
                        ln_neg   = 1'b1;
                        ln_phase = PH_LNUM;
                    end
                    else if (is_num(b))
                    begin
                        ln_left      = add_digit(ln_left, b, lcap);
                        ln_left_seen = 1'b1;
                        ln_phase     = PH_LNUM;
                    end
                    else
                        ln_phase = PH_GAP;
                end
            end
            PH_LNUM:
            begin
                if (is_num(b))
                begin
                    ln_left      = add_digit(ln_left, b, lcap);
                    ln_left_seen = 1'b1;
                end
                else
                    ln_phase = PH_GAP;
            end
            PH_GAP:
            begin
                if (is_num(b))
                begin
                    ln_right = add_digit(ln_right, b, MAG_MAX);
                    ln_phase = PH_RNUM;
                end
            end
            PH_RNUM:
            begin
                if (is_num(b))
                    ln_right = add_digit(ln_right, b, MAG_MAX);
                else
                    ln_phase = PH_TAIL;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // one text byte on s_axis; tvalid stays up after the word is taken so the
    // next call can present new data without a low pulse in between
    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // stop sending and wait until every predicted edge has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (edges_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // the register takes the value at the edge where cfg_we is seen high
    task automatic write_header_lines(input logic [HDR_BITS-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        hdr_limit = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // random text
    // ------------------------------------------------------------------

    // add one byte to the end of the line under construction
    task automatic append_byte(input logic [BYTE_BITS-1:0] b);
        text_line.insert(text_line.size(), b);
    endtask

    function automatic logic [BYTE_BITS-1:0] pick_blank();
        case ($urandom_range(4))
            0:       return CH_TAB;
            1:       return CH_VT;
            2:       return CH_FF;
            3:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // mostly short numbers, some long enough to saturate, some missing
    function automatic int digit_count();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 25)
            return $urandom_range(13, 10);
        return $urandom_range(6, 1);
    endfunction

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
            append_byte(CH_ZERO + 8'($urandom_range(9)));
    endtask

    // one line: mostly well-formed edges, some comments, some raw noise
    task automatic build_line();
        int    kind;
        string seps = " \t,;:";
        string junk = "ab z-+09.#*\015\t";

        text_line.delete();
        kind = $urandom_range(99);
        if (kind < 72)
        begin
            repeat ($urandom_range(2)) append_byte(pick_blank());
            case ($urandom_range(9))
                0:       append_byte(CH_PLUS);
                1, 2:    append_byte(CH_MINUS);
                default: ;
            endcase
            push_digits(digit_count());
            repeat ($urandom_range(3, 1)) append_byte(seps[$urandom_range(4)]);
            push_digits(digit_count());
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(6, 1))
                    append_byte(junk[$urandom_range(junk.len() - 1)]);
        end
        else if (kind < 82)
        begin
            append_byte($urandom_range(1) ? CH_HASH : CH_STAR);
            repeat ($urandom_range(8)) append_byte(8'($urandom_range(255)));
        end
        else
        begin
            // any byte value at all, newlines included
            repeat ($urandom_range(12, 1)) append_byte(8'($urandom_range(255)));
        end
        append_byte(CH_NL);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // header lines are dropped even when they look like edges; the count is
    // checked against whatever the register holds at the time
    task automatic test_header_skip();
        write_header_lines(16'd0);
        write_header_lines(16'hffff);
        send_text("1 2\n#x\n");
        send_byte(8'hff);
        send_byte(8'h00);
        send_text(" 9\n");
        settle();
        // three lines seen, two more to go
        write_header_lines(16'd5);
        send_text("7 8\n\n");
        settle();
        // limit now below the count: parsing starts with the next byte
        write_header_lines(16'd2);
    endtask

    // hand-picked lines around the limits and the odd cases
    task automatic test_edge_lines();
        send_text("1 2\n");
        send_text("-2147483648 2147483647\n");        // exact limits, no clamp
        send_text("2147483648 2147483648\n");         // one past on both
        send_text("-2147483649 99999999999\n");       // clamp negative and right
        send_text("+0 0\n-0 1\n");
        send_text("\n");                              // empty edge line
        send_text(" \t\013\014\015\n");               // blanks only
        send_text("+\n");                             // sign, nothing else
        send_text("- 5\n+x12\n");                     // sign with no digits after it
        send_text("# 1 2\n* 3 4\n");                  // comments
        send_text(" #5 6\n");                         // marker not in first column
        send_text("007,0008 junk 99\n");              // tail ignored
        send_text("12\n3 4\015\n");
        send_byte(8'h80);                             // high bytes are neither
        send_byte(CH_SPACE);
        send_byte(8'hff);
        send_text(" 42 7\n");
        settle();
    endtask

    // once edges are flowing the register no longer matters
    task automatic test_late_config();
        write_header_lines(16'hffff);
        send_text("5 6\n");
        settle();
        write_header_lines(16'd0);
        send_text("-7 8\n");
        settle();
    endtask

    task automatic random_phase(input int gap_pct, input int stall_pct, input int n_bytes);
        int start;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        start = random_sent;
        while (random_sent - start < n_bytes)
        begin
            build_line();
            foreach (text_line[i])
                send_byte(text_line[i]);
            random_sent += text_line.size();
        end
        // hold the sender until the sink has caught up before the next phase
        settle();
    endtask

    task automatic test_random_mix();
        random_phase(0, 0, RANDOM_BYTES / 4);
        random_phase(86, 0, RANDOM_BYTES / 4);
        random_phase(0, 86, RANDOM_BYTES / 4);
        random_phase(18, 18, RANDOM_BYTES / 4);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // sink, checker and watchdog
    // ------------------------------------------------------------------

    // sink backpressure, redrawn every cycle
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // each edge word against the oldest prediction
    always @(posedge clk)
    begin
        edge_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (edges_due.size() == 0)
            begin
                $display("%0t: unexpected edge word tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = edges_due.pop_front();
                if (m_axis_tdata[LEFT_BITS-1:0] !== want.left_vertex)
                begin
                    $display("%0t: left_vertex expected %h got %h",
                             $time, want.left_vertex, m_axis_tdata[LEFT_BITS-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[LEFT_BITS +: RIGHT_BITS] !== want.right_vertex)
                begin
                    $display("%0t: right_vertex expected %h got %h",
                             $time, want.right_vertex, m_axis_tdata[LEFT_BITS +: RIGHT_BITS]);
                    fail_count++;
                end
                if (m_axis_tdata[DATA_BITS-1] !== 1'b0)
                begin
                    $display("%0t: tdata pad bit expected 0 got %b",
                             $time, m_axis_tdata[DATA_BITS-1]);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== want.left_empty)
                begin
                    $display("%0t: left_empty expected %b got %b",
                             $time, want.left_empty, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tuser[1] !== want.saturated)
                begin
                    $display("%0t: saturated expected %b got %b",
                             $time, want.saturated, m_axis_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    // a run of cycles with no word moving either way ends the run
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("edge_list_integer_parser_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_skip();
        test_edge_lines();
        test_late_config();
        test_random_mix();

        settle();
        if (fail_count == 0)
            $display("edge_list_integer_parser_top test passed");
        else
            $display("edge_list_integer_parser_top test failed");
        $finish;
    end

endmodule
